[rtl/core/tablet_pen_event_generator_macros.svh]
// Assertion macros used by the pen event generator checker.
`ifndef TABLET_PEN_EVENT_GENERATOR_MACROS_SVH
`define TABLET_PEN_EVENT_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TPEG_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TPEG_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tpeg_pkg.sv]
// Types, codes and constants of the tablet pen event generator.
package tpeg_pkg;

	localparam int SWITCH_COUNT     = 4;
	localparam int NUM_SLOTS        = 9;
	localparam int SLOT_IDX_W       = $clog2(NUM_SLOTS);
	localparam int NUM_EDGE_BUTTONS = 3;
	localparam int NUM_BUTTON_BITS  = 5;

	// Fixed slot order of the events one report can cause.
	localparam int SLOT_RELEASE  = 0;
	localparam int SLOT_PROX_OUT = 3;
	localparam int SLOT_PROX_IN  = 4;
	localparam int SLOT_MOTION   = 5;
	localparam int SLOT_PRESS    = 6;

	localparam logic [3:0] SW_MASK = 4'((1 << SWITCH_COUNT) - 1);

	typedef enum logic [1:0] {
		KIND_MOTION = 2'd0,
		KIND_BUTTON = 2'd1,
		KIND_PROX   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CUR_NONE    = 2'd0,
		CUR_STYLUS  = 2'd1,
		CUR_ERASER  = 2'd2
	} cur_t;

	typedef enum logic [2:0] {
		CFG_PRESSURE_THRESHOLD = 3'd0,
		CFG_SUPPRESS_DISTANCE  = 3'd1,
		CFG_TOOLS_ENABLED      = 3'd2,
		CFG_CORE_POINTER_TOOLS = 3'd3,
		CFG_ABSOLUTE_MODE      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        [15:0] x;
		logic        [15:0] y;
		logic        [11:0] p;
		logic signed [7:0]  tx;
		logic signed [7:0]  ty;
	} sample_t;

	typedef struct packed {
		logic [11:0] threshold;
		logic [15:0] suppress;
		logic [1:0]  tools_en;
		logic [1:0]  core;
		logic        abs_mode;
	} cfg_t;

	typedef struct packed {
		sample_t    smp;
		logic [3:0] sw;
		logic       rng;
		logic       inv;
	} item_t;

	typedef struct packed {
		cur_t                                cur;
		sample_t [1:0]                       saved;
		logic    [1:0][NUM_BUTTON_BITS-1:0]  buttons;
		logic    [1:0]                       seen;
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic       tool;
		logic [1:0] btn;
		logic       level;
		logic       absf;
		logic       use_new;
	} slot_t;

endpackage

[rtl/core/tpeg_event_calc.sv]
// Event list and next tool state for one pen report.
module tpeg_event_calc (
	input  tpeg_pkg::item_t                             item,
	input  tpeg_pkg::cfg_t                              cfg,
	input  tpeg_pkg::state_t                            st,
	output tpeg_pkg::slot_t [tpeg_pkg::NUM_SLOTS-1:0]   slots,
	output logic [tpeg_pkg::NUM_SLOTS-1:0]              mask,
	output tpeg_pkg::state_t                            nxt
);

	always_comb begin
		logic [tpeg_pkg::NUM_BUTTON_BITS-1:0] buttons;
		logic                                 old_valid;
		logic                                 ot;
		logic                                 t;
		logic                                 active;
		logic                                 entering;
		logic [15:0]                          dx;
		logic [15:0]                          dy;
		logic                                 same;
		logic                                 moved;
		tpeg_pkg::sample_t                    sv;

		buttons   = {item.sw & tpeg_pkg::SW_MASK, item.smp.p > cfg.threshold};
		old_valid = (st.cur == tpeg_pkg::CUR_STYLUS) || (st.cur == tpeg_pkg::CUR_ERASER);
		ot        = (st.cur == tpeg_pkg::CUR_ERASER);
		t         = item.inv;
		active    = item.rng && cfg.tools_en[t];
		entering  = active && (st.cur != tpeg_pkg::cur_t'({t, !t}));
		sv        = st.saved[t];
		dx        = (item.smp.x > sv.x) ? item.smp.x - sv.x : sv.x - item.smp.x;
		dy        = (item.smp.y > sv.y) ? item.smp.y - sv.y : sv.y - item.smp.y;
		moved     = (item.smp.x != sv.x) || (item.smp.y != sv.y) || (item.smp.p != sv.p) ||
		            (item.smp.tx != sv.tx) || (item.smp.ty != sv.ty);
		same      = (buttons == st.buttons[t]) && st.seen[t] &&
		            (dx < cfg.suppress) && (dy < cfg.suppress) &&
		            (item.smp.p == sv.p) && (item.smp.tx == sv.tx) && (item.smp.ty == sv.ty);

		nxt  = st;
		mask = '0;

		// Fixed fields of every slot.
		for (int b = 0; b < tpeg_pkg::NUM_EDGE_BUTTONS; b++) begin
			slots[tpeg_pkg::SLOT_RELEASE + b] = '{kind: tpeg_pkg::KIND_BUTTON, tool: ot,
				btn: 2'(b + 1), level: 1'b0, absf: cfg.abs_mode, use_new: 1'b0};
			slots[tpeg_pkg::SLOT_PRESS + b] = '{kind: tpeg_pkg::KIND_BUTTON, tool: t,
				btn: 2'(b + 1), level: buttons[b], absf: cfg.abs_mode, use_new: 1'b1};
		end
		slots[tpeg_pkg::SLOT_PROX_OUT] = '{kind: tpeg_pkg::KIND_PROX, tool: ot, btn: 2'd0,
			level: 1'b0, absf: 1'b0, use_new: 1'b0};
		slots[tpeg_pkg::SLOT_PROX_IN] = '{kind: tpeg_pkg::KIND_PROX, tool: t, btn: 2'd0,
			level: 1'b1, absf: 1'b0, use_new: 1'b1};
		slots[tpeg_pkg::SLOT_MOTION] = '{kind: tpeg_pkg::KIND_MOTION, tool: t, btn: 2'd0,
			level: 1'b0, absf: 1'b1, use_new: 1'b1};

		// Take the old tool out of proximity, releasing its held buttons.
		if (!item.rng || entering) begin
			nxt.cur = tpeg_pkg::CUR_NONE;
			if (old_valid) begin
				for (int b = 0; b < tpeg_pkg::NUM_EDGE_BUTTONS; b++)
					mask[tpeg_pkg::SLOT_RELEASE + b] = st.buttons[ot][b];
				mask[tpeg_pkg::SLOT_PROX_OUT] = !cfg.core[ot];
				nxt.buttons[ot] = '0;
			end
		end

		if (entering) begin
			nxt.cur = tpeg_pkg::cur_t'({t, !t});
			mask[tpeg_pkg::SLOT_PROX_IN] = !cfg.core[t];
		end

		// Motion and button edges of tool t beyond the deadband.
		if (active && !same) begin
			mask[tpeg_pkg::SLOT_MOTION] = moved;
			for (int b = 0; b < tpeg_pkg::NUM_EDGE_BUTTONS; b++)
				mask[tpeg_pkg::SLOT_PRESS + b] = buttons[b] != st.buttons[t][b];
			nxt.saved[t]   = item.smp;
			nxt.buttons[t] = buttons;
			nxt.seen[t]    = 1'b1;
		end
	end

endmodule

[rtl/core/tablet_pen_event_generator.sv]
// Top level of the tablet pen event generator.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | in        | in_valid / in_stall   | pos_x pos_y pressure tilt_x tilt_y
//          |           |                       | barrel_switches proximity inverted
//  out     | out       | out_valid / out_stall | event_kind tool button_number level
//          |           |                       | abs_flag out_x out_y out_pressure
//          |           |                       | out_tilt_x out_tilt_y last
//  cfg     | in        | cfg_write             | cfg_index cfg_data
//
// A report waits in the input register until the event buffer takes it; its 0 to 9 events
// then leave the event buffer one per cycle while out_stall is low.
// The next report is taken into the input register while the buffer still drains, and
// its events are computed and loaded in the cycle the last event before it transfers.
// arst_n clears the control path and tool state and resets cfg_q; data registers are not reset.
// out_stall holds the current event; in_stall rises only while the input register waits.
module tablet_pen_event_generator (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        pos_x,
	input  logic [15:0]        pos_y,
	input  logic [11:0]        pressure,
	input  logic signed [7:0]  tilt_x,
	input  logic signed [7:0]  tilt_y,
	input  logic [3:0]         barrel_switches,
	input  logic               proximity,
	input  logic               inverted,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic               tool,
	output logic [1:0]         button_number,
	output logic               level,
	output logic               abs_flag,
	output logic [15:0]        out_x,
	output logic [15:0]        out_y,
	output logic [11:0]        out_pressure,
	output logic signed [7:0]  out_tilt_x,
	output logic signed [7:0]  out_tilt_y,
	output logic               last
);

	// Configuration registers.
	tpeg_pkg::cfg_t cfg_q;

	// Input register: one report waiting for the event buffer.
	tpeg_pkg::item_t item_s1;
	logic            item_valid_s1;

	// Tool proximity state and the last sample of each tool.
	tpeg_pkg::state_t state_q;
	tpeg_pkg::state_t state_nxt;

	// Event buffer: per-slot fields, pending mask and the two samples events carry.
	tpeg_pkg::slot_t [tpeg_pkg::NUM_SLOTS-1:0] slot_q;
	tpeg_pkg::slot_t [tpeg_pkg::NUM_SLOTS-1:0] slot_nxt;
	logic [tpeg_pkg::NUM_SLOTS-1:0]            mask_q;
	logic [tpeg_pkg::NUM_SLOTS-1:0]            mask_nxt;
	logic [tpeg_pkg::NUM_SLOTS-1:0]            mask_rest;
	tpeg_pkg::sample_t                         old_smp_q;
	tpeg_pkg::sample_t                         new_smp_q;

	logic [tpeg_pkg::SLOT_IDX_W-1:0] sel;
	tpeg_pkg::slot_t                 cur_slot;
	tpeg_pkg::sample_t               cur_smp;
	logic                            in_xfer;
	logic                            out_xfer;
	logic                            load;

	tpeg_event_calc u_calc (
		.item  (item_s1),
		.cfg   (cfg_q),
		.st    (state_q),
		.slots (slot_nxt),
		.mask  (mask_nxt),
		.nxt   (state_nxt)
	);

	// Lowest pending slot goes out first; slot order is event order.
	always_comb begin
		sel = '0;
		for (int i = tpeg_pkg::NUM_SLOTS - 1; i >= 0; i--)
			if (mask_q[i])
				sel = tpeg_pkg::SLOT_IDX_W'(i);
	end

	assign mask_rest = mask_q & (mask_q - 1'b1);
	assign cur_slot  = slot_q[sel];
	assign cur_smp   = cur_slot.use_new ? new_smp_q : old_smp_q;

	assign out_valid = |mask_q;
	assign out_xfer  = out_valid && !out_stall;
	// Load the next report once the buffer is empty or hands over its final event.
	assign load      = item_valid_s1 && (!out_valid || (out_xfer && mask_rest == '0));
	assign in_stall  = item_valid_s1 && !load;
	assign in_xfer   = in_valid && !in_stall;

	assign event_kind    = cur_slot.kind;
	assign tool          = cur_slot.tool;
	assign button_number = cur_slot.btn;
	assign level         = cur_slot.level;
	assign abs_flag      = cur_slot.absf;
	assign out_x         = cur_smp.x;
	assign out_y         = cur_smp.y;
	assign out_pressure  = cur_smp.p;
	assign out_tilt_x    = cur_smp.tx;
	assign out_tilt_y    = cur_smp.ty;
	assign last          = mask_rest == '0;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= 12'd0;
			cfg_q.suppress  <= 16'd2;
			cfg_q.tools_en  <= 2'd1;
			cfg_q.core      <= 2'd0;
			cfg_q.abs_mode  <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				tpeg_pkg::CFG_PRESSURE_THRESHOLD: cfg_q.threshold <= cfg_data[11:0];
				tpeg_pkg::CFG_SUPPRESS_DISTANCE:  cfg_q.suppress  <= cfg_data;
				tpeg_pkg::CFG_TOOLS_ENABLED:      cfg_q.tools_en  <= cfg_data[1:0];
				tpeg_pkg::CFG_CORE_POINTER_TOOLS: cfg_q.core      <= cfg_data[1:0];
				tpeg_pkg::CFG_ABSOLUTE_MODE:      cfg_q.abs_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register valid: set on an input transfer, drop when loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			item_valid_s1 <= 1'b1;
		end else if (load) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.smp.x  <= pos_x;
			item_s1.smp.y  <= pos_y;
			item_s1.smp.p  <= pressure;
			item_s1.smp.tx <= tilt_x;
			item_s1.smp.ty <= tilt_y;
			item_s1.sw     <= barrel_switches;
			item_s1.rng    <= proximity;
			item_s1.inv    <= inverted;
		end
	end

	// Tool state and pending mask advance together with the load; else a transfer clears the sent event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			mask_q  <= '0;
		end else begin
			if (load) begin
				state_q <= state_nxt;
				mask_q  <= mask_nxt;
			end else if (out_xfer) begin
				mask_q  <= mask_rest;
			end
		end
	end

	// Event payload: the old tool's saved sample and the new report's sample.
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q    <= slot_nxt;
			old_smp_q <= state_q.saved[state_q.cur == tpeg_pkg::CUR_ERASER];
			new_smp_q <= item_s1.smp;
		end
	end

endmodule

[rtl/core/tpeg_checker.sv]
// Port-level checks of the pen event generator, bound to the top level.
`include "tablet_pen_event_generator_macros.svh"

module tpeg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         event_kind,
	input logic               tool,
	input logic [1:0]         button_number,
	input logic               level,
	input logic               abs_flag,
	input logic [15:0]        out_x,
	input logic [15:0]        out_y,
	input logic [11:0]        out_pressure,
	input logic signed [7:0]  out_tilt_x,
	input logic signed [7:0]  out_tilt_y,
	input logic               last
);

	`TPEG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(tool) && $stable(button_number) && $stable(level) && $stable(abs_flag) && $stable(out_x) && $stable(out_y) && $stable(out_pressure) && $stable(out_tilt_x) && $stable(out_tilt_y) && $stable(last), "stalled event changed")
	`TPEG_ASSERT_IMP(a_motion_fields, out_valid && event_kind == tpeg_pkg::KIND_MOTION, button_number == 2'd0 && !level && abs_flag, "motion event fields wrong")
	`TPEG_ASSERT_IMP(a_prox_fields, out_valid && event_kind == tpeg_pkg::KIND_PROX, button_number == 2'd0 && !abs_flag, "proximity event fields wrong")
	`TPEG_ASSERT_IMP(a_button_number, out_valid && event_kind == tpeg_pkg::KIND_BUTTON, button_number != 2'd0, "button event without number")

endmodule

bind tablet_pen_event_generator tpeg_checker u_tpeg_checker (.*);

[verif/tablet_pen_event_generator_tb.sv]
// Self-checking testbench for the tablet pen event generator.
`timescale 1ns / 100ps

module tablet_pen_event_generator_tb;

	// Run limit in clock cycles.
	localparam int RUN_LIMIT = 1000000;
	// Cycles the receiver holds off in the back-pressure phase.
	localparam int HOLD_CYCLES = 300;
	// Cycles a report may still be in flight after the last event has left.
	localparam int SETTLE_CYCLES = 4;

	// One event as seen on the output channel.
	typedef struct packed {
		tpeg_pkg::kind_t   kind;
		logic              tool;
		logic [1:0]        btn;
		logic              level;
		logic              absf;
		tpeg_pkg::sample_t smp;
		logic              last;
	} pen_event_t;

	// Tracks proximity, the saved sample of each tool and the register copy; builds the
	// event list of each accepted report and checks transfers against it in order.
	class pen_event_scoreboard;
		logic [11:0]       threshold;
		logic [15:0]       deadband;
		logic [1:0]        tools_on;
		logic [1:0]        core_tools;
		logic              abs_mode;
		tpeg_pkg::cur_t    in_prox;
		tpeg_pkg::sample_t saved[2];
		logic [4:0]        saved_btns[2];
		logic              seen[2];
		pen_event_t        events_due[$];
		pen_event_t        report_events[$];
		int                errors;

		function new();
			threshold  = '0;
			deadband   = 16'd2;
			tools_on   = 2'b01;
			core_tools = 2'b00;
			abs_mode   = 1'b1;
			in_prox    = tpeg_pkg::CUR_NONE;
			for (int t = 0; t < 2; t++) begin
				saved[t]      = '0;
				saved_btns[t] = '0;
				seen[t]       = 1'b0;
			end
			errors = 0;
		endfunction

		function void set_reg(tpeg_pkg::cfg_idx_t idx, logic [15:0] val);
			case (idx)
				tpeg_pkg::CFG_PRESSURE_THRESHOLD: threshold = val[11:0];
				tpeg_pkg::CFG_SUPPRESS_DISTANCE:  deadband = val;
				tpeg_pkg::CFG_TOOLS_ENABLED:      tools_on = val[1:0];
				tpeg_pkg::CFG_CORE_POINTER_TOOLS: core_tools = val[1:0];
				tpeg_pkg::CFG_ABSOLUTE_MODE:      abs_mode = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return events_due.size();
		endfunction

		function void push(tpeg_pkg::kind_t k, int t, int b, logic lv, logic af,
				tpeg_pkg::sample_t s);
			pen_event_t ev;
			ev.kind  = k;
			ev.tool  = t[0];
			ev.btn   = b[1:0];
			ev.level = lv;
			ev.absf  = af;
			ev.smp   = s;
			ev.last  = 1'b0;
			report_events.push_back(ev);
		endfunction

		function int distance(logic [15:0] a, logic [15:0] b);
			return (a > b) ? int'(a - b) : int'(b - a);
		endfunction

		// Edges of buttons 1 to 3; the two upper button bits never make an event.
		function void edge_events(int t, logic [4:0] nb, tpeg_pkg::sample_t s);
			for (int b = 1; b < 4; b++)
				if (saved_btns[t][b-1] != nb[b-1])
					push(tpeg_pkg::KIND_BUTTON, t, b, nb[b-1], abs_mode, s);
		endfunction

		// Release what the tool in proximity holds, then announce that it left unless it is a core tool.
		function void leave_prox();
			int t;
			if (in_prox == tpeg_pkg::CUR_NONE)
				return;
			t = (in_prox == tpeg_pkg::CUR_ERASER) ? 1 : 0;
			in_prox = tpeg_pkg::CUR_NONE;
			if (saved_btns[t] != '0) begin
				edge_events(t, 5'b0, saved[t]);
				saved_btns[t] = '0;
			end
			if (!core_tools[t])
				push(tpeg_pkg::KIND_PROX, t, 0, 1'b0, 1'b0, saved[t]);
		endfunction

		function void note_report(tpeg_pkg::sample_t s, logic [3:0] sw, logic rng, logic inv);
			logic [4:0] nb;
			int         t;
			logic       quiet;
			nb = '0;
			for (int i = 0; i < tpeg_pkg::SWITCH_COUNT && i < 4; i++)
				if (sw[i])
					nb[i+1] = 1'b1;
			if (s.p > threshold)
				nb[0] = 1'b1;
			report_events.delete();
			if (!rng) begin
				leave_prox();
			end else if (tools_on[inv]) begin
				t = inv ? 1 : 0;
				if (in_prox != (inv ? tpeg_pkg::CUR_ERASER : tpeg_pkg::CUR_STYLUS)) begin
					leave_prox();
					in_prox = inv ? tpeg_pkg::CUR_ERASER : tpeg_pkg::CUR_STYLUS;
					if (!core_tools[t])
						push(tpeg_pkg::KIND_PROX, t, 0, 1'b1, 1'b0, s);
				end
				quiet = nb == saved_btns[t] && seen[t] &&
					distance(s.x, saved[t].x) < deadband &&
					distance(s.y, saved[t].y) < deadband &&
					s.p == saved[t].p && s.tx == saved[t].tx && s.ty == saved[t].ty;
				if (!quiet) begin
					if (s != saved[t])
						push(tpeg_pkg::KIND_MOTION, t, 0, 1'b0, 1'b1, s);
					if (nb != saved_btns[t])
						edge_events(t, nb, s);
					saved[t]      = s;
					saved_btns[t] = nb;
					seen[t]       = 1'b1;
				end
			end
			if (report_events.size() > 0)
				report_events[report_events.size()-1].last = 1'b1;
			foreach (report_events[i])
				events_due.push_back(report_events[i]);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_event(pen_event_t got);
			pen_event_t want;
			if (events_due.size() == 0) begin
				errors++;
				$display("%0t: event expected none, actual kind %0h tool %0h x %0h y %0h",
					$time, got.kind, got.tool, got.smp.x, got.smp.y);
				return;
			end
			want = events_due.pop_front();
			compare_field("event_kind", want.kind, got.kind);
			compare_field("tool", want.tool, got.tool);
			compare_field("button_number", want.btn, got.btn);
			compare_field("level", want.level, got.level);
			compare_field("abs_flag", want.absf, got.absf);
			compare_field("out_x", want.smp.x, got.smp.x);
			compare_field("out_y", want.smp.y, got.smp.y);
			compare_field("out_pressure", want.smp.p, got.smp.p);
			compare_field("out_tilt_x", want.smp.tx, got.smp.tx);
			compare_field("out_tilt_y", want.smp.ty, got.smp.ty);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic [2:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [15:0]       pos_x;
	logic [15:0]       pos_y;
	logic [11:0]       pressure;
	logic signed [7:0] tilt_x;
	logic signed [7:0] tilt_y;
	logic [3:0]        barrel_switches;
	logic              proximity;
	logic              inverted;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        event_kind;
	logic              tool;
	logic [1:0]        button_number;
	logic              level;
	logic              abs_flag;
	logic [15:0]       out_x;
	logic [15:0]       out_y;
	logic [11:0]       out_pressure;
	logic signed [7:0] out_tilt_x;
	logic signed [7:0] out_tilt_y;
	logic              last;

	pen_event_scoreboard sb;

	// Pen as the random stimulus sees it; reports mostly walk from this sample.
	logic [15:0] pen_x;
	logic [15:0] pen_y;
	logic [11:0] pen_p;
	logic [7:0]  pen_tx;
	logic [7:0]  pen_ty;
	logic [3:0]  pen_sw;
	logic        pen_inv;
	logic [11:0] thr_now;

	// Set by the stimulus, cleared by the receiver once its long hold-off is over.
	bit hold_req;
	int cycles;

	tablet_pen_event_generator DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bound the run; a hang or a missing event ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("tablet_pen_event_generator: mismatch");
			$finish;
		end
	end

	// Check every event that transfers; values are taken as they stood at the edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_event('{kind: tpeg_pkg::kind_t'(event_kind), tool: tool,
				btn: button_number, level: level, absf: abs_flag,
				smp: '{x: out_x, y: out_y, p: out_pressure, tx: out_tilt_x, ty: out_tilt_y},
				last: last});
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Receiver: alternate runs of ready cycles with stalls; hold off long on request.
	initial begin
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = idle_cycles();
				if (n == 0) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Write all five registers on consecutive edges; only call with the block idle.
	task automatic program_regs(logic [11:0] thr, logic [15:0] db, logic [1:0] tl,
			logic [1:0] cp, logic ab);
		tpeg_pkg::cfg_idx_t idx[5];
		logic [15:0]        val[5];
		idx = '{tpeg_pkg::CFG_PRESSURE_THRESHOLD, tpeg_pkg::CFG_SUPPRESS_DISTANCE,
			tpeg_pkg::CFG_TOOLS_ENABLED, tpeg_pkg::CFG_CORE_POINTER_TOOLS,
			tpeg_pkg::CFG_ABSOLUTE_MODE};
		val = '{16'(thr), db, 16'(tl), 16'(cp), 16'(ab)};
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
		thr_now = thr;
	endtask

	// Offer one report, hold it until the transfer, then idle for a random gap.
	// Keep valid high across back-to-back reports; drop it only when a gap follows.
	task automatic send_report(logic [15:0] x, logic [15:0] y, logic [11:0] p,
			logic [7:0] tx, logic [7:0] ty, logic [3:0] sw, logic rng, logic inv);
		int gap;
		in_valid        <= 1'b1;
		pos_x           <= x;
		pos_y           <= y;
		pressure        <= p;
		tilt_x          <= tx;
		tilt_y          <= ty;
		barrel_switches <= sw;
		proximity       <= rng;
		inverted        <= inv;
		do @(posedge clk); while (in_stall);
		sb.note_report('{x: x, y: y, p: p, tx: tx, ty: ty}, sw, rng, inv);
		// Offer back to back while the receiver holds off, so the block fills up.
		gap = hold_req ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Step the pen: mostly well-formed strokes, some leaving range, tool flips,
	// repeats and jitter around the deadband, plus a little pure noise.
	task automatic random_report();
		int   r;
		logic rng;
		logic inv;
		r   = $urandom_range(0, 99);
		rng = 1'b1;
		if (r < 5) begin
			pen_x   = 16'($urandom);
			pen_y   = 16'($urandom);
			pen_p   = 12'($urandom);
			pen_tx  = 8'($urandom);
			pen_ty  = 8'($urandom);
			pen_sw  = 4'($urandom);
			pen_inv = 1'($urandom);
			rng     = 1'($urandom);
		end else if (r < 12) begin
			rng = 1'b0;
		end else if (r < 18) begin
			pen_inv = ~pen_inv;
		end else if (r < 28) begin
			// resend the same sample
		end else if (r < 50) begin
			pen_x = pen_x + 16'($urandom_range(0, 6)) - 16'd3;
			pen_y = pen_y + 16'($urandom_range(0, 6)) - 16'd3;
		end else begin
			pen_x = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: pen_x + 16'($urandom_range(0, 64)) - 16'd32;
			pen_y = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: pen_y + 16'($urandom_range(0, 64)) - 16'd32;
			pen_p = $urandom_range(0, 1) ? 12'($urandom)
				: 12'(thr_now + $urandom_range(0, 4) - 2);
			if ($urandom_range(0, 2) == 0) begin
				pen_tx = 8'($urandom);
				pen_ty = 8'($urandom);
			end
			if ($urandom_range(0, 3) == 0)
				pen_sw = 4'($urandom);
		end
		// Out of range, the other fields carry whatever the decoder left there.
		inv = rng ? pen_inv : 1'($urandom);
		send_report(pen_x, pen_y, pen_p, pen_tx, pen_ty, pen_sw, rng, inv);
	endtask

	// Drop valid, wait for every expected event, then let a silent report settle.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int count;
		arst_n          = 1'b0;
		cfg_write       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		pos_x           = '0;
		pos_y           = '0;
		pressure        = '0;
		tilt_x          = '0;
		tilt_y          = '0;
		barrel_switches = '0;
		proximity       = 1'b0;
		inverted        = 1'b0;
		pen_x           = '0;
		pen_y           = '0;
		pen_p           = '0;
		pen_tx          = '0;
		pen_ty          = '0;
		pen_sw          = '0;
		pen_inv         = 1'b0;
		thr_now         = '0;
		hold_req        = 1'b0;
		cycles          = 0;
		count           = 0;
		sb = new();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, both tools on, proximity events for both.
		program_regs(12'd100, 16'd2, 2'b11, 2'b00, 1'b1);
		send_report(16'd0, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b1, 1'b0);
		// identical sample: suppressed, no event
		send_report(16'd0, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b1, 1'b0);
		// field maxima: motion and buttons 1 to 3 down, buttons 4 and 5 silent
		send_report(16'hFFFF, 16'hFFFF, 12'hFFF, 8'h7F, 8'h80, 4'hF, 1'b1, 1'b0);
		send_report(16'hFFFF, 16'hFFFF, 12'd50, 8'h80, 8'h7F, 4'h8, 1'b1, 1'b0);
		// move inside the deadband
		send_report(16'hFFFE, 16'hFFFF, 12'd50, 8'h80, 8'h7F, 4'h8, 1'b1, 1'b0);
		// tool change while only a silent button is held
		send_report(16'd100, 16'd200, 12'hFFF, 8'h01, 8'hFF, 4'h1, 1'b1, 1'b1);
		// leave range with buttons held, then stay out
		send_report(16'd0, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0);
		send_report(16'd0, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0);
		// re-enter with the saved sample: proximity and buttons, no motion
		send_report(16'd100, 16'd200, 12'hFFF, 8'h01, 8'hFF, 4'h3, 1'b1, 1'b1);
		// tool change with three held and three pressed: nine events
		send_report(16'd300, 16'd400, 12'hFFF, 8'h02, 8'h02, 4'h3, 1'b1, 1'b0);
		send_report(16'd301, 16'd401, 12'hFFF, 8'h02, 8'h02, 4'h3, 1'b1, 1'b0);
		// move of exactly the deadband
		send_report(16'd302, 16'd400, 12'hFFF, 8'h02, 8'h02, 4'h3, 1'b1, 1'b0);
		// pressure at and just above the threshold
		send_report(16'd302, 16'd400, 12'd100, 8'h02, 8'h02, 4'h3, 1'b1, 1'b0);
		send_report(16'd302, 16'd400, 12'd101, 8'h02, 8'h02, 4'h3, 1'b1, 1'b0);
		// only switch 2 changes: stored, no event
		send_report(16'd302, 16'd400, 12'd101, 8'h02, 8'h02, 4'h7, 1'b1, 1'b0);
		send_report(16'd0, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b0, 1'b1);
		wait_quiet();

		// Directed, eraser off and its proximity events masked, relative buttons.
		program_regs(12'd0, 16'hFFFF, 2'b01, 2'b10, 1'b0);
		send_report(16'd5, 16'd5, 12'd10, 8'h00, 8'h00, 4'h0, 1'b1, 1'b1);
		send_report(16'd0, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b1, 1'b0);
		// full-scale move escapes the widest deadband
		send_report(16'hFFFF, 16'd0, 12'd0, 8'h00, 8'h00, 4'h0, 1'b1, 1'b0);
		send_report(16'd9, 16'd9, 12'd9, 8'h00, 8'h00, 4'h0, 1'b1, 1'b1);
		// disabled tool out of range still takes the stylus out
		send_report(16'd9, 16'd9, 12'd9, 8'h00, 8'h00, 4'h0, 1'b0, 1'b1);
		send_report(16'hFFFF, 16'd0, 12'd1, 8'h00, 8'h00, 4'h1, 1'b1, 1'b0);
		wait_quiet();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin program_regs(12'($urandom), 16'd3, 2'b11, 2'b00, 1'b1); count = 80; end
				1: begin program_regs(12'd0, 16'd0, 2'b11, 2'b11, 1'b0); count = 70; end
				2: begin program_regs(12'hFFF, 16'hFFFF, 2'b10, 2'b01, 1'b1); count = 60; end
				3: begin
					program_regs(12'($urandom), 16'($urandom_range(0, 300)), 2'b11,
						2'($urandom), 1'($urandom));
					count = 80;
				end
				4: begin program_regs(12'($urandom), 16'd1, 2'b01, 2'b00, 1'b0); count = 60; end
				5: begin program_regs(12'd0, 16'd0, 2'b00, 2'b00, 1'b1); count = 15; end
				default: begin program_regs(12'd2048, 16'd16, 2'b11, 2'b10, 1'b1); count = 80; end
			endcase
			// Let the receiver hold off while reports keep coming.
			if (ph == 1)
				hold_req = 1'b1;
			repeat (count) random_report();
			wait_quiet();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tablet_pen_event_generator: match");
		else
			$display("tablet_pen_event_generator: mismatch");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tpeg_pkg.sv
rtl/core/tpeg_event_calc.sv
rtl/core/tablet_pen_event_generator.sv
rtl/core/tpeg_checker.sv
verif/tablet_pen_event_generator_tb.sv
